FILE: hw/rtl/data_and_multiply_instruction_encoder_assert.svh
// Assertion helpers for the instruction encoder.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef DATA_AND_MULTIPLY_INSTRUCTION_ENCODER_ASSERT_SVH
`define DATA_AND_MULTIPLY_INSTRUCTION_ENCODER_ASSERT_SVH

// same-cycle implication
`define DMIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dmie_pkg.sv
package dmie_pkg;

    localparam int ROT_COUNT = 16;
    localparam int ROT_W     = 4;

    typedef logic [3:0]  reg_num_t;
    typedef logic [3:0]  op_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] word_t;

    localparam op_t OP_ADD = 4'd0;
    localparam op_t OP_SUB = 4'd1;
    localparam op_t OP_RSB = 4'd2;
    localparam op_t OP_AND = 4'd3;
    localparam op_t OP_EOR = 4'd4;
    localparam op_t OP_ORR = 4'd5;
    localparam op_t OP_MOV = 4'd6;
    localparam op_t OP_TST = 4'd7;
    localparam op_t OP_TEQ = 4'd8;
    localparam op_t OP_CMP = 4'd9;
    localparam op_t OP_MUL = 4'd10;
    localparam op_t OP_MLA = 4'd11;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_BAD_IMM = 2'd1;
    localparam status_t STATUS_BAD_OP  = 2'd2;

    localparam logic [3:0] COND_ALWAYS = 4'hE;
    localparam logic [3:0] MUL_MARK    = 4'h9;

    typedef struct packed {
        op_t      op;
        reg_num_t rd;
        reg_num_t rn;
        reg_num_t rm;
        reg_num_t rs;
    } inst_t;

    // rotate left by an arbitrary amount
    function automatic word_t rotl32(word_t v, logic [4:0] amt);
        logic [63:0] d;
        d = {v, v} << amt;
        return d[63:32];
    endfunction

    // rotate right by an arbitrary amount
    function automatic word_t rotr32(word_t v, logic [4:0] amt);
        logic [63:0] d;
        d = {v, v} >> amt;
        return d[31:0];
    endfunction

    // data-processing opcode field
    function automatic logic [3:0] dp_opcode(op_t op);
        logic [3:0] code;
        case (op)
            OP_AND:  code = 4'b0000;
            OP_EOR:  code = 4'b0001;
            OP_SUB:  code = 4'b0010;
            OP_RSB:  code = 4'b0011;
            OP_ADD:  code = 4'b0100;
            OP_TST:  code = 4'b1000;
            OP_TEQ:  code = 4'b1001;
            OP_CMP:  code = 4'b1010;
            OP_ORR:  code = 4'b1100;
            OP_MOV:  code = 4'b1101;
            default: code = 4'b0000;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/dmie_imm_check.sv
module dmie_imm_check (
    input  logic [31:0]                  value,
    output logic [dmie_pkg::ROT_COUNT-1:0] fit
);
    import dmie_pkg::*;

    // lane r: value rotated left by 2r leaves only the low byte set
    always_comb
    begin
        word_t rot;
        for (int r = 0; r < ROT_COUNT; r++)
        begin
            rot = rotl32(value, 5'(2 * r));
            fit[r] = (rot[31:8] == 24'd0);
        end
    end

endmodule

FILE: hw/rtl/data_and_multiply_instruction_encoder.sv
// Channel   | Handshake              | Beat contents
// ----------+------------------------+------------------------------------------------
// input     | in_valid / in_ready    | operation, dest_reg, first_reg, mul_m_reg,
//           |                        | mul_s_reg, immediate
// output    | out_valid / out_ready  | instruction_word, status
//
// Four register stages: input capture, rotation fit flags, smallest-rotation
// pick, word assembly. One beat a cycle is sustained while out_ready is high.
// Each stage has its own valid bit and load enable, so bubbles close up and
// a stall at the output only holds stages that are full.
// rst_n (async, active low) clears the valid bits; payload is not reset.
// in_ready drops only when all four stages are full and out_ready is low.
module data_and_multiply_instruction_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dmie_pkg::op_t              operation,
    input  dmie_pkg::reg_num_t         dest_reg,
    input  dmie_pkg::reg_num_t         first_reg,
    input  dmie_pkg::reg_num_t         mul_m_reg,
    input  dmie_pkg::reg_num_t         mul_s_reg,
    input  logic [31:0]                immediate,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                instruction_word,
    output dmie_pkg::status_t          status
);
    import dmie_pkg::*;

    // stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    // stage 1: captured beat
    inst_t s1_inst_reg;
    word_t s1_imm_reg;

    // stage 2: fit flags per rotation
    inst_t                s2_inst_reg;
    word_t                s2_imm_reg;
    logic [ROT_COUNT-1:0] s2_fit_reg;
    logic [ROT_COUNT-1:0] s1_fit;

    // stage 3: chosen operand field
    inst_t            s3_inst_reg;
    word_t            s3_imm_reg;
    logic             s3_found_reg;
    logic [ROT_W-1:0] s3_rot_reg;
    logic [7:0]       s3_imm8_reg;
    logic             s3_found_next;
    logic [ROT_W-1:0] s3_rot_next;
    logic [7:0]       s3_imm8_next;

    // stage 4: output register
    word_t   s4_word_reg;
    status_t s4_status_reg;
    word_t   s4_word_next;
    status_t s4_status_next;

    // a stage loads when it is empty or its content moves on
    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1 -> 2: 16 parallel fit checks
    dmie_imm_check u_imm_check (
        .value (s1_imm_reg),
        .fit   (s1_fit)
    );

    // stage 2 -> 3: lowest fitting rotation wins
    always_comb
    begin
        word_t rot_val;
        s3_found_next = 1'b0;
        s3_rot_next   = '0;
        for (int r = ROT_COUNT - 1; r >= 0; r--)
        begin
            if (s2_fit_reg[r])
            begin
                s3_found_next = 1'b1;
                s3_rot_next   = ROT_W'(r);
            end
        end
        rot_val      = rotl32(s2_imm_reg, {s3_rot_next, 1'b0});
        s3_imm8_next = rot_val[7:0];
    end

    // stage 3 -> 4: word assembly
    always_comb
    begin
        logic       s_bit;
        reg_num_t   nreg;
        reg_num_t   dreg;
        logic       acc;
        s4_word_next   = '0;
        s4_status_next = STATUS_OK;
        s_bit          = 1'b0;
        nreg           = s3_inst_reg.rn;
        dreg           = s3_inst_reg.rd;
        acc            = (s3_inst_reg.op == OP_MLA);
        if (s3_inst_reg.op inside {[OP_ADD:OP_CMP]})
        begin
            // compare forms set S and drop Rd; mov drops Rn
            if (s3_inst_reg.op inside {[OP_TST:OP_CMP]})
            begin
                s_bit = 1'b1;
                dreg  = '0;
            end
            else if (s3_inst_reg.op == OP_MOV)
            begin
                nreg = '0;
            end
            if (s3_found_reg)
            begin
                s4_word_next = {COND_ALWAYS, 2'b00, 1'b1, dp_opcode(s3_inst_reg.op),
                                s_bit, nreg, dreg, s3_rot_reg, s3_imm8_reg};
            end
            else
            begin
                s4_status_next = STATUS_BAD_IMM;
            end
        end
        else if (s3_inst_reg.op inside {[OP_MUL:OP_MLA]})
        begin
            // plain multiply carries no accumulate register
            s4_word_next = {COND_ALWAYS, 6'b000000, acc, 1'b0, s3_inst_reg.rd,
                            (acc ? s3_inst_reg.rn : 4'd0), s3_inst_reg.rs,
                            MUL_MARK, s3_inst_reg.rm};
        end
        else
        begin
            s4_status_next = STATUS_BAD_OP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_inst_reg <= '{op: operation, rd: dest_reg, rn: first_reg,
                             rm: mul_m_reg, rs: mul_s_reg};
            s1_imm_reg  <= immediate;
        end
        if (en2)
        begin
            s2_inst_reg <= s1_inst_reg;
            s2_imm_reg  <= s1_imm_reg;
            s2_fit_reg  <= s1_fit;
        end
        if (en3)
        begin
            s3_inst_reg  <= s2_inst_reg;
            s3_imm_reg   <= s2_imm_reg;
            s3_found_reg <= s3_found_next;
            s3_rot_reg   <= s3_rot_next;
            s3_imm8_reg  <= s3_imm8_next;
        end
        if (en4)
        begin
            s4_word_reg   <= s4_word_next;
            s4_status_reg <= s4_status_next;
        end
    end

    assign out_valid        = s4_valid_reg;
    assign instruction_word = s4_word_reg;
    assign status           = s4_status_reg;

`include "data_and_multiply_instruction_encoder_assert.svh"

    // the chosen field must reproduce the immediate
    `DMIE_ASSERT_NOW(a_field_round_trip,
        s3_valid_reg && s3_found_reg,
        rotr32({24'd0, s3_imm8_reg}, {s3_rot_reg, 1'b0}) == s3_imm_reg,
        "picked rotation does not rebuild the immediate")

    // zero always fits at rotation 0
    `DMIE_ASSERT_NOW(a_zero_fits,
        s2_valid_reg && (s2_imm_reg == 32'd0),
        s2_fit_reg[0],
        "zero immediate not flagged as fitting")

    // failed encodings carry an all-zero word
    `DMIE_ASSERT_NOW(a_error_word_zero,
        out_valid && (status != STATUS_OK),
        instruction_word == 32'd0,
        "nonzero word with error status")

    // an output stall must keep the beat queued behind it
    `DMIE_ASSERT_NEXT(a_stall_keeps_s3,
        s3_valid_reg && s4_valid_reg && !out_ready,
        s3_valid_reg,
        "stage 3 beat lost during output stall")

endmodule
